### hw/rtl/gyro_frame_sync_decoder_assert.svh
// assertion macros shared by the gyro frame sync decoder modules
`ifndef GYRO_FRAME_SYNC_DECODER_ASSERT_SVH
`define GYRO_FRAME_SYNC_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define GFSD_ASSERT_IMPLY(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("gfsd assertion failed");
// next-cycle implication, checked out of reset
`define GFSD_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("gfsd assertion failed");
`else
`define GFSD_ASSERT_IMPLY(name, clk, rst, pre, post)
`define GFSD_ASSERT_NEXT(name, clk, rst, pre, post)
`endif
`endif

### hw/rtl/gfsd_pkg.sv
// shared types and constants for the gyro frame sync decoder
package gfsd_pkg;

   localparam int RATE_W           = 22;
   localparam int BYTE_W           = 8;
   localparam int SEQ_W            = 2;
   localparam int SEEK_W           = 8;
   localparam int CSR_INDEX_W      = 2;
   localparam int CSR_DATA_W       = RATE_W;
   localparam int FRAME_BYTES_DEF  = 6;
   localparam int QUEUE_DEPTH      = 2;

   // frame positions that carry the rate bytes
   localparam int GATHER_FIRST     = 3;
   localparam int GATHER_LAST      = 5;

   // header patterns accepted before lock
   localparam logic [BYTE_W-1:0] HDR_SEQ0 = 8'h10;
   localparam logic [BYTE_W-1:0] HDR_SEQ1 = 8'h50;
   localparam logic [BYTE_W-1:0] HDR_SEQ2 = 8'h90;
   localparam logic [BYTE_W-1:0] HDR_SEQ3 = 8'hD0;

   localparam logic [SEEK_W-1:0] SEEK_MAX = 8'd255;

   // register reset values
   localparam logic [RATE_W-1:0] REJECT_THRESHOLD_RESET = 22'd1027684;
   localparam logic [SEEK_W-1:0] SEEK_LIMIT_RESET       = 8'd7;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_REJECT_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEEK_LIMIT       = 2'd1;

   typedef enum logic [1:0] {
      STATUS_ACCEPT    = 2'd0,
      STATUS_OVER      = 2'd1,
      STATUS_SEEK_FAIL = 2'd2
   } status_type;

   typedef enum logic {
      EVT_FRAME     = 1'b0,
      EVT_SEEK_FAIL = 1'b1
   } event_kind_type;

   // classified event passed from front to back
   typedef struct packed {
      event_kind_type           kind;
      logic signed [RATE_W-1:0] rate;
      logic [SEQ_W-1:0]         sequence_res;
   } event_type;

endpackage

### hw/rtl/gfsd_front.sv
// byte front end: header search, frame tracking and rate assembly
module gfsd_front #(
   parameter int FRAME_BYTES = gfsd_pkg::FRAME_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic [gfsd_pkg::BYTE_W-1:0]        req_rx_byte,
   input  logic                               queue_full,
   input  logic [gfsd_pkg::SEEK_W-1:0]        seek_limit,
   output logic                               req_stall,
   output logic                               push,
   output gfsd_pkg::event_type                push_event
);
   import gfsd_pkg::*;

   localparam int POS_W = $clog2(FRAME_BYTES);
   localparam logic [POS_W-1:0] POS_SEEK  = '0;
   localparam logic [POS_W-1:0] POS_FIRST = POS_W'(1);
   localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);
   localparam logic [POS_W-1:0] POS_G_LO  = POS_W'(GATHER_FIRST);
   localparam logic [POS_W-1:0] POS_G_HI  = POS_W'(GATHER_LAST);

   logic              locked_ff, locked_in;
   logic [SEQ_W-1:0]  last_seq_ff, last_seq_in;
   logic [POS_W-1:0]  frame_pos_ff, frame_pos_in;
   logic [SEEK_W-1:0] seek_count_ff, seek_count_in;
   logic [RATE_W-1:0] gather_ff, gather_in;

   logic              accept;
   logic              is_header;
   logic [SEQ_W-1:0]  next_seq;
   logic [SEEK_W-1:0] seek_inc;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // header check, strict pattern before lock and sequence follow after
   assign next_seq = last_seq_ff + SEQ_W'(1);
   always_comb begin
      if (!locked_ff) begin
         is_header = req_rx_byte inside {HDR_SEQ0, HDR_SEQ1, HDR_SEQ2, HDR_SEQ3};
      end else begin
         is_header = (req_rx_byte[7:6] == next_seq) && req_rx_byte[4] && !req_rx_byte[5];
      end
   end

   assign seek_inc = (seek_count_ff == SEEK_MAX) ? seek_count_ff : seek_count_ff + SEEK_W'(1);

   // next state and event generation
   always_comb begin
      locked_in     = locked_ff;
      last_seq_in   = last_seq_ff;
      frame_pos_in  = frame_pos_ff;
      seek_count_in = seek_count_ff;
      gather_in     = gather_ff;
      push          = 1'b0;
      push_event.kind         = EVT_FRAME;
      push_event.rate         = '0;
      push_event.sequence_res = last_seq_ff;
      if (accept) begin
         if (frame_pos_ff == POS_SEEK) begin
            if (is_header) begin
               locked_in     = 1'b1;
               last_seq_in   = req_rx_byte[7:6];
               frame_pos_in  = POS_FIRST;
               seek_count_in = '0;
            end else if ((seek_limit != '0) && (seek_inc >= seek_limit)) begin
               seek_count_in   = '0;
               push            = 1'b1;
               push_event.kind = EVT_SEEK_FAIL;
            end else begin
               seek_count_in = seek_inc;
            end
         end else begin
            if ((frame_pos_ff >= POS_G_LO) && (frame_pos_ff <= POS_G_HI)) begin
               gather_in = {gather_ff[RATE_W-BYTE_W-1:0], req_rx_byte};
            end
            if (frame_pos_ff == POS_LAST) begin
               frame_pos_in    = POS_SEEK;
               push            = 1'b1;
               push_event.rate = gather_in;
            end else begin
               frame_pos_in = frame_pos_ff + POS_W'(1);
            end
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         locked_ff     <= 1'b0;
         last_seq_ff   <= '0;
         frame_pos_ff  <= POS_SEEK;
         seek_count_ff <= '0;
      end else begin
         locked_ff     <= locked_in;
         last_seq_ff   <= last_seq_in;
         frame_pos_ff  <= frame_pos_in;
         seek_count_ff <= seek_count_in;
      end
   end

   // rate bytes, always fully overwritten before use
   always_ff @(posedge clock) begin
      gather_ff <= gather_in;
   end

endmodule

### hw/rtl/gfsd_queue.sv
// two-entry event queue between front and back
`include "gyro_frame_sync_decoder_assert.svh"
module gfsd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  gfsd_pkg::event_type push_event,
   input  logic                pop,
   output gfsd_pkg::event_type pop_event,
   output logic                full,
   output logic                empty
);
   import gfsd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   event_type        entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_FULL);
   assign empty     = (count_ff == '0);
   assign pop_event = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_event;
      end
   end

   `GFSD_ASSERT_IMPLY(a_no_push_full, clock, reset, push, !full || pop)
   `GFSD_ASSERT_IMPLY(a_no_pop_empty, clock, reset, pop, !empty)
   `GFSD_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + CNT_W'(1))

endmodule

### hw/rtl/gfsd_back.sv
// back end: threshold check, held rate and result register
`include "gyro_frame_sync_decoder_assert.svh"
module gfsd_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                queue_empty,
   input  gfsd_pkg::event_type                 pop_event,
   input  logic [gfsd_pkg::RATE_W-1:0]         reject_threshold,
   input  logic                                rsp_stall,
   output logic                                pop,
   output logic                                rsp_valid,
   output logic signed [gfsd_pkg::RATE_W-1:0]  rsp_rate_count,
   output logic signed [gfsd_pkg::RATE_W-1:0]  rsp_held_rate,
   output logic [gfsd_pkg::SEQ_W-1:0]          rsp_sequence_res,
   output logic [1:0]                          rsp_status
);
   import gfsd_pkg::*;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [RATE_W-1:0] rate_ff, rate_in;
   logic signed [RATE_W-1:0] held_ff, held_in;
   logic [SEQ_W-1:0]         seq_ff;
   status_type               status_ff, status_in;
   logic signed [RATE_W-1:0] good_rate_ff, good_rate_in;

   logic [RATE_W-1:0]        magnitude;
   logic                     over;
   logic                     is_frame;

   // take the next event once the result register is free or being taken
   assign pop = !queue_empty && (!rsp_valid_ff || !rsp_stall);

   // magnitude of the 22-bit rate, most negative maps to 2^21
   assign magnitude = pop_event.rate[RATE_W-1] ? (~pop_event.rate + RATE_W'(1))
                                               : pop_event.rate;
   assign is_frame  = (pop_event.kind == EVT_FRAME);
   assign over      = is_frame && (magnitude > reject_threshold);

   // result formation
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      good_rate_in = good_rate_ff;
      rate_in      = '0;
      status_in    = STATUS_SEEK_FAIL;
      if (is_frame) begin
         rate_in   = pop_event.rate;
         status_in = over ? STATUS_OVER : STATUS_ACCEPT;
         if (!over) begin
            good_rate_in = pop_event.rate;
         end
      end
      held_in = good_rate_in;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else begin
         good_rate_in = good_rate_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         good_rate_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         good_rate_ff <= good_rate_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         rate_ff   <= rate_in;
         held_ff   <= held_in;
         seq_ff    <= pop_event.sequence_res;
         status_ff <= status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rate_count   = rate_ff;
   assign rsp_held_rate    = held_ff;
   assign rsp_sequence_res = seq_ff;
   assign rsp_status       = status_ff;

   `GFSD_ASSERT_IMPLY(a_accept_held, clock, reset, rsp_valid_ff && (status_ff == STATUS_ACCEPT), rate_ff == held_ff)
   `GFSD_ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_valid_ff && (status_ff == STATUS_SEEK_FAIL), rate_ff == '0)
   `GFSD_ASSERT_NEXT(a_held_tracks, clock, reset, pop, held_ff == good_rate_ff)

endmodule

### hw/rtl/gyro_frame_sync_decoder.sv
// top level of the gyro frame sync decoder
//
// Takes one received gyro byte per clock while req_stall is low, finds frame
// headers, assembles the 22-bit rate of each FRAME_BYTES-byte frame and
// returns one result per frame (status 0 accepted, 1 over threshold) or per
// failed header search (status 2). The front end classifies a byte in the
// cycle it arrives and hands any result through a two-entry queue to the back
// end, which registers it, so a result passes the queue entry and the result
// register. req_stall rises only while that queue is full, which happens only
// when rsp_stall holds results back. Registers take effect at once and are
// meant to be written while no frame is in progress; register writes with an
// index beyond the two registers are ignored.
module gyro_frame_sync_decoder #(
   parameter int FRAME_BYTES = gfsd_pkg::FRAME_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [gfsd_pkg::BYTE_W-1:0]         req_rx_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [gfsd_pkg::RATE_W-1:0]  rsp_rate_count,
   output logic signed [gfsd_pkg::RATE_W-1:0]  rsp_held_rate,
   output logic [gfsd_pkg::SEQ_W-1:0]          rsp_sequence_res,
   output logic [1:0]                          rsp_status,
   input  logic                                csr_wr_en,
   input  logic [gfsd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gfsd_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import gfsd_pkg::*;

   logic [RATE_W-1:0] reject_threshold_ff, reject_threshold_in;
   logic [SEEK_W-1:0] seek_limit_ff, seek_limit_in;

   logic      push;
   logic      pop;
   logic      queue_full;
   logic      queue_empty;
   event_type push_event;
   event_type pop_event;

   // configuration registers
   always_comb begin
      reject_threshold_in = reject_threshold_ff;
      seek_limit_in       = seek_limit_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_REJECT_THRESHOLD: reject_threshold_in = csr_wr_data;
            CSR_SEEK_LIMIT:       seek_limit_in       = csr_wr_data[SEEK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reject_threshold_ff <= REJECT_THRESHOLD_RESET;
         seek_limit_ff       <= SEEK_LIMIT_RESET;
      end else begin
         reject_threshold_ff <= reject_threshold_in;
         seek_limit_ff       <= seek_limit_in;
      end
   end

   // header search and frame assembly
   gfsd_front #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .queue_full  (queue_full),
      .seek_limit  (seek_limit_ff),
      .req_stall   (req_stall),
      .push        (push),
      .push_event  (push_event)
   );

   // event queue
   gfsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .pop        (pop),
      .pop_event  (pop_event),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   // threshold check and result register
   gfsd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_empty      (queue_empty),
      .pop_event        (pop_event),
      .reject_threshold (reject_threshold_ff),
      .rsp_stall        (rsp_stall),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_rate_count   (rsp_rate_count),
      .rsp_held_rate    (rsp_held_rate),
      .rsp_sequence_res (rsp_sequence_res),
      .rsp_status       (rsp_status)
   );

endmodule
